// ===== hw/rtl/nce_pkg.sv =====
// shared types and constants for the noise channel lfsr envelope unit
// event codes, register offsets and the decoded command carried front to back
// no dependencies
package nce_pkg;

	// event codes on the operation field
	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_TIMER  = 2'd1;
	localparam logic [1:0] OP_ENV    = 2'd2;
	localparam logic [1:0] OP_LENGTH = 2'd3;

	// register offsets on the reg_select field
	localparam logic [1:0] REG_CTRL   = 2'd0;
	localparam logic [1:0] REG_UNUSED = 2'd1;
	localparam logic [1:0] REG_MODE   = 2'd2;
	localparam logic [1:0] REG_LOAD   = 2'd3;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [3:0] LEVEL_MAX = 4'hF;

	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_CTRL,
		CMD_MODE,
		CMD_LOAD,
		CMD_TIMER,
		CMD_ENV,
		CMD_LEN
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic        halt;
		logic        const_vol;
		logic [3:0]  env_period;
		logic        short_mode;
		logic [11:0] timer_period;
		logic        len_load;
		logic [7:0]  len_value;
	} cmd_t;

endpackage

// ===== hw/rtl/nce_front.sv =====
// front end: classifies each incoming event and decodes register data
// uses nce_pkg for event codes and the command struct
module nce_front (
	input  logic [1:0]   operation,
	input  logic [1:0]   reg_select,
	input  logic [7:0]   write_data,
	input  logic         channel_enable,
	output nce_pkg::cmd_t cmd
);

	// ntsc noise timer periods
	function automatic logic [11:0] period_lookup(input logic [3:0] idx);
		logic [11:0] p;
		begin
			case (idx)
				4'd0:    p = 12'd4;
				4'd1:    p = 12'd8;
				4'd2:    p = 12'd16;
				4'd3:    p = 12'd32;
				4'd4:    p = 12'd64;
				4'd5:    p = 12'd96;
				4'd6:    p = 12'd128;
				4'd7:    p = 12'd160;
				4'd8:    p = 12'd202;
				4'd9:    p = 12'd254;
				4'd10:   p = 12'd380;
				4'd11:   p = 12'd508;
				4'd12:   p = 12'd762;
				4'd13:   p = 12'd1016;
				4'd14:   p = 12'd2034;
				default: p = 12'd4068;
			endcase
			return p;
		end
	endfunction

	function automatic logic [7:0] length_lookup(input logic [4:0] idx);
		logic [7:0] l;
		begin
			case (idx)
				5'd0:    l = 8'd10;
				5'd1:    l = 8'd254;
				5'd2:    l = 8'd20;
				5'd3:    l = 8'd2;
				5'd4:    l = 8'd40;
				5'd5:    l = 8'd4;
				5'd6:    l = 8'd80;
				5'd7:    l = 8'd6;
				5'd8:    l = 8'd160;
				5'd9:    l = 8'd8;
				5'd10:   l = 8'd60;
				5'd11:   l = 8'd10;
				5'd12:   l = 8'd14;
				5'd13:   l = 8'd12;
				5'd14:   l = 8'd26;
				5'd15:   l = 8'd14;
				5'd16:   l = 8'd12;
				5'd17:   l = 8'd16;
				5'd18:   l = 8'd24;
				5'd19:   l = 8'd18;
				5'd20:   l = 8'd48;
				5'd21:   l = 8'd20;
				5'd22:   l = 8'd96;
				5'd23:   l = 8'd22;
				5'd24:   l = 8'd192;
				5'd25:   l = 8'd24;
				5'd26:   l = 8'd72;
				5'd27:   l = 8'd26;
				5'd28:   l = 8'd16;
				5'd29:   l = 8'd28;
				5'd30:   l = 8'd32;
				default: l = 8'd30;
			endcase
			return l;
		end
	endfunction

	always_comb begin
		cmd              = '0;
		cmd.halt         = write_data[5];
		cmd.const_vol    = write_data[4];
		cmd.env_period   = write_data[3:0];
		cmd.short_mode   = write_data[7];
		cmd.timer_period = period_lookup(write_data[3:0]);
		cmd.len_load     = channel_enable;
		cmd.len_value    = length_lookup(write_data[7:3]);
		case (operation)
			nce_pkg::OP_WRITE: begin
				case (reg_select)
					nce_pkg::REG_CTRL: cmd.kind = nce_pkg::CMD_CTRL;
					nce_pkg::REG_MODE: cmd.kind = nce_pkg::CMD_MODE;
					nce_pkg::REG_LOAD: cmd.kind = nce_pkg::CMD_LOAD;
					default:           cmd.kind = nce_pkg::CMD_NOP;
				endcase
			end
			nce_pkg::OP_TIMER:  cmd.kind = nce_pkg::CMD_TIMER;
			nce_pkg::OP_ENV:    cmd.kind = nce_pkg::CMD_ENV;
			nce_pkg::OP_LENGTH: cmd.kind = nce_pkg::CMD_LEN;
			default:            cmd.kind = nce_pkg::CMD_NOP;
		endcase
	end

endmodule

// ===== hw/rtl/nce_queue.sv =====
// short command queue between front and back ends
// uses nce_pkg for the command struct and queue depth
module nce_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  nce_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output nce_pkg::cmd_t pop_cmd
);

	nce_pkg::cmd_t mem_q [nce_pkg::QDEPTH];
	logic [nce_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [nce_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [nce_pkg::QCNT_W-1:0] count_q;

	function automatic logic [nce_pkg::QPTR_W-1:0] ptr_next(
		input logic [nce_pkg::QPTR_W-1:0] p
	);
		logic [nce_pkg::QPTR_W-1:0] n;
		begin
			if (p == nce_pkg::QPTR_W'(nce_pkg::QDEPTH - 1)) begin
				n = '0;
			end else begin
				n = p + 1'b1;
			end
			return n;
		end
	endfunction

	assign full      = (count_q == nce_pkg::QCNT_W'(nce_pkg::QDEPTH));
	assign not_empty = (count_q != '0);
	assign pop_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/nce_back.sv =====
// back end: channel state, lfsr, envelope, length counter and sample register
// uses nce_pkg for the command struct
module nce_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  nce_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [3:0]    sample
);

	logic [14:0] lfsr_q;
	logic        short_mode_q;
	logic [11:0] timer_period_q;
	logic [11:0] timer_count_q;
	logic        halt_q;
	logic [7:0]  length_count_q;
	logic        const_vol_q;
	logic [3:0]  env_period_q;
	logic        env_start_q;
	logic [3:0]  env_level_q;
	logic [3:0]  env_div_q;
	logic        out_valid_q;
	logic [3:0]  sample_q;

	logic [14:0] lfsr_d;
	logic        short_mode_d;
	logic [11:0] timer_period_d;
	logic [11:0] timer_count_d;
	logic        halt_d;
	logic [7:0]  length_count_d;
	logic        const_vol_d;
	logic [3:0]  env_period_d;
	logic        env_start_d;
	logic [3:0]  env_level_d;
	logic [3:0]  env_div_d;
	logic [3:0]  sample_d;
	logic        fb;

	// take a command when the sample register is free or being emptied
	assign cmd_pop   = cmd_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign sample    = sample_q;

	always_comb begin
		lfsr_d         = lfsr_q;
		short_mode_d   = short_mode_q;
		timer_period_d = timer_period_q;
		timer_count_d  = timer_count_q;
		halt_d         = halt_q;
		length_count_d = length_count_q;
		const_vol_d    = const_vol_q;
		env_period_d   = env_period_q;
		env_start_d    = env_start_q;
		env_level_d    = env_level_q;
		env_div_d      = env_div_q;
		fb = lfsr_q[0] ^ (short_mode_q ? lfsr_q[6] : lfsr_q[1]);
		case (cmd.kind)
			nce_pkg::CMD_CTRL: begin
				halt_d       = cmd.halt;
				const_vol_d  = cmd.const_vol;
				env_period_d = cmd.env_period;
			end
			nce_pkg::CMD_MODE: begin
				short_mode_d   = cmd.short_mode;
				timer_period_d = cmd.timer_period;
			end
			nce_pkg::CMD_LOAD: begin
				if (cmd.len_load) begin
					length_count_d = cmd.len_value;
				end
				env_start_d = 1'b1;
			end
			nce_pkg::CMD_TIMER: begin
				if (timer_count_q == '0) begin
					timer_count_d = timer_period_q;
					lfsr_d        = {fb, lfsr_q[14:1]};
				end else begin
					timer_count_d = timer_count_q - 1'b1;
				end
			end
			nce_pkg::CMD_ENV: begin
				if (env_start_q) begin
					env_start_d = 1'b0;
					env_level_d = nce_pkg::LEVEL_MAX;
					env_div_d   = env_period_q;
				end else if (env_div_q == '0) begin
					env_div_d = env_period_q;
					if (env_level_q != '0) begin
						env_level_d = env_level_q - 1'b1;
					end else if (halt_q) begin
						env_level_d = nce_pkg::LEVEL_MAX;
					end
				end else begin
					env_div_d = env_div_q - 1'b1;
				end
			end
			nce_pkg::CMD_LEN: begin
				if (!halt_q && length_count_q != '0) begin
					length_count_d = length_count_q - 1'b1;
				end
			end
			default: ;
		endcase
		if (length_count_d == '0 || lfsr_d[0]) begin
			sample_d = '0;
		end else begin
			sample_d = const_vol_d ? env_period_d : env_level_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q         <= 15'd1;
			short_mode_q   <= 1'b0;
			timer_period_q <= '0;
			timer_count_q  <= '0;
			halt_q         <= 1'b0;
			length_count_q <= '0;
			const_vol_q    <= 1'b0;
			env_period_q   <= '0;
			env_start_q    <= 1'b0;
			env_level_q    <= '0;
			env_div_q      <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cmd_pop) begin
				lfsr_q         <= lfsr_d;
				short_mode_q   <= short_mode_d;
				timer_period_q <= timer_period_d;
				timer_count_q  <= timer_count_d;
				halt_q         <= halt_d;
				length_count_q <= length_count_d;
				const_vol_q    <= const_vol_d;
				env_period_q   <= env_period_d;
				env_start_q    <= env_start_d;
				env_level_q    <= env_level_d;
				env_div_q      <= env_div_d;
				out_valid_q    <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			sample_q <= sample_d;
		end
	end

`ifndef SYNTH
	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != '0)
		else $error("lfsr reached the all-zero state");

	a_silent_sample: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (length_count_q == '0 || lfsr_q[0]) |-> sample_q == '0)
		else $error("sample not silenced");

	a_load_starts_env: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop && cmd.kind == nce_pkg::CMD_LOAD |=> env_start_q)
		else $error("length load did not restart envelope");

	a_halt_holds_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop && cmd.kind == nce_pkg::CMD_LEN && halt_q |=> $stable(length_count_q))
		else $error("length counter moved while halted");
`endif

endmodule

// ===== hw/rtl/noise_channel_lfsr_envelope_unit.sv =====
// top level of the noise channel: lfsr noise voice with envelope and length counter
// instantiates nce_front, nce_queue and nce_back; uses nce_pkg
//
// channel | handshake            | payload
// --------+----------------------+-------------------------------------------------
// in      | in_valid / in_ready  | operation, reg_select, write_data, channel_enable
// out     | out_valid / out_ready| sample
//
// one event per clock sustained while out_ready is held high
// each event passes through the two-entry command queue and then the sample output register
// in_ready drops only when the queue is full, i.e. the output has stalled
// arst_n clears lfsr to one and all other channel state but the sample register to zero, queue empty
// no clearing pass: the block takes events from the first edge after reset
module noise_channel_lfsr_envelope_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  logic [1:0] reg_select,
	input  logic [7:0] write_data,
	input  logic       channel_enable,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] sample
);

	nce_pkg::cmd_t front_cmd;
	nce_pkg::cmd_t queue_cmd;
	logic          q_full;
	logic          q_not_empty;
	logic          q_pop;
	logic          q_push;

	// decode the event into a command right at the input
	nce_front u_front (
		.operation      (operation),
		.reg_select     (reg_select),
		.write_data     (write_data),
		.channel_enable (channel_enable),
		.cmd            (front_cmd)
	);

	// accept while the queue has room, independent of the output side
	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	nce_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (front_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_cmd   (queue_cmd)
	);

	// execute commands in order and register each resulting sample
	nce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_not_empty),
		.cmd       (queue_cmd),
		.cmd_pop   (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample    (sample)
	);

endmodule
